// ===== rtl/assert_macros.svh =====
// Assertion macros used by the adder top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: label");

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

// ===== rtl/fpadd_pkg.sv =====
// Package: constants and inter-stage types for the e7m8 adder
package fpadd_pkg;

   localparam logic [6:0]  EXP_MAX  = 7'h7F;
   localparam logic [15:0] NAN_CODE = 16'hFF01;
   localparam logic [15:0] INF_POS  = 16'h7F00;

   // stage 1 -> stage 2: operands ordered, special result decided
   typedef struct packed {
      logic        special;
      logic [15:0] special_val;
      logic        sign;
      logic        sub;
      logic [6:0]  exp;
      logic [11:0] ma;
      logic [11:0] mb;
   } align_type;

   // stage 2 -> stage 3: raw sum before normalisation
   typedef struct packed {
      logic        special;
      logic [15:0] special_val;
      logic        sign;
      logic [7:0]  exp;
      logic [12:0] sum;
   } norm_type;

   // stage 3 -> stage 4: normalised, awaiting rounding
   typedef struct packed {
      logic        special;
      logic [15:0] special_val;
      logic        sign;
      logic [7:0]  exp;
      logic [11:0] sum;
   } round_type;

   // leading zero count over the 12-bit sum, capped at 12
   function automatic logic [3:0] lzc12(input logic [11:0] v);
      logic [3:0] n;
      logic       found;
      n = 4'd12;
      found = 1'b0;
      for (int i = 11; i >= 0; i--) begin
         if (!found && v[i]) begin
            n = 4'(11 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

endpackage

// ===== rtl/fp16_e7m8_adder.sv =====
// Top level: four-stage pipelined e7m8 floating-point adder
// Adds two 16-bit floats (sign, 7-bit exponent bias 63, 8-bit fraction),
// rounding to nearest even with subnormal support; NaN returns 0xFF01.
// Four register stages: an accepted pair moves through stages 1 to 4, and rsp_valid
// is the valid flag of stage 4. One beat can be accepted every cycle while req_stall
// is low. Stages: unpack/order, align and add, normalise, round
// and pack. A stall on rsp_stall holds each full stage with no empty stage after it;
// bubbles are squeezed out, so req_stall rises only when every stage is full.
`include "assert_macros.svh"
module fp16_e7m8_adder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_operand_a,
   input  logic [15:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_sum
);
   fpadd_pkg::align_type align_in, align_ff;
   fpadd_pkg::norm_type  norm_in, norm_ff;
   fpadd_pkg::round_type round_in, round_ff;
   logic [6:0]  diff_in, diff_ff;
   logic [15:0] sum_in, sum_ff;
   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic        en1, en2, en3, en4;

   fpadd_unpack u_unpack (
      .a_in(req_operand_a), .b_in(req_operand_b),
      .align_out(align_in), .diff_out(diff_in));

   fpadd_addnorm u_addnorm (
      .align_in(align_ff), .diff_in(diff_ff), .norm_out(norm_in),
      .norm_in(norm_ff), .round_out(round_in));

   fpadd_round u_round (.round_in(round_ff), .result_out(sum_in));

   // a stage advances when its successor is empty or advancing
   assign en4 = !v4_ff || !rsp_stall;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_stall = !en1;
   assign rsp_valid = v4_ff;
   assign rsp_sum   = sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         align_ff <= align_in;
         diff_ff  <= diff_in;
      end
      if (en2) norm_ff  <= norm_in;
      if (en3) round_ff <= round_in;
      if (en4) sum_ff   <= sum_in;
   end

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_sum))
   `ASSERT_ALWAYS(a_stall_full, clock, reset, !req_stall || (v1_ff && v2_ff && v3_ff && v4_ff))
   `ASSERT_NEXT(a_enter, clock, reset, req_valid && !req_stall, v1_ff)
endmodule

// ===== rtl/fpadd_unpack.sv =====
// Stage 1 logic: special cases, operand ordering and exponent difference
module fpadd_unpack (
   input  logic [15:0]          a_in,
   input  logic [15:0]          b_in,
   output fpadd_pkg::align_type align_out,
   output logic [6:0]           diff_out
);
   logic [6:0]  ea, eb, eg, el;
   logic [7:0]  fa, fb;
   logic        a_nan, b_nan, a_inf, b_inf, swap;
   logic [15:0] big, lit;

   always_comb begin
      ea = a_in[14:8];
      eb = b_in[14:8];
      fa = a_in[7:0];
      fb = b_in[7:0];
      a_inf = (ea == fpadd_pkg::EXP_MAX) && (fa == 8'd0);
      b_inf = (eb == fpadd_pkg::EXP_MAX) && (fb == 8'd0);
      a_nan = (ea == fpadd_pkg::EXP_MAX) && (fa != 8'd0);
      b_nan = (eb == fpadd_pkg::EXP_MAX) && (fb != 8'd0);
      swap  = b_in[14:0] > a_in[14:0];
      big   = swap ? b_in : a_in;
      lit   = swap ? a_in : b_in;

      align_out.special     = 1'b1;
      align_out.special_val = 16'd0;
      if (a_nan || b_nan || (a_inf && b_inf && (a_in[15] != b_in[15])))
         align_out.special_val = fpadd_pkg::NAN_CODE;
      else if (a_inf)
         align_out.special_val = a_in;
      else if (b_inf)
         align_out.special_val = b_in;
      else if (big[14:0] == lit[14:0] && big[15] != lit[15])
         align_out.special_val = 16'd0;
      else if (big[14:0] == 15'd0)
         align_out.special_val = {a_in[15] & b_in[15], 15'd0};
      else
         align_out.special = 1'b0;

      eg = (big[14:8] == 7'd0) ? 7'd1 : big[14:8];
      el = (lit[14:8] == 7'd0) ? 7'd1 : lit[14:8];
      align_out.sign = big[15];
      align_out.sub  = big[15] != lit[15];
      align_out.exp  = eg;
      align_out.ma   = {(big[14:8] != 7'd0), big[7:0], 3'b000};
      align_out.mb   = {(lit[14:8] != 7'd0), lit[7:0], 3'b000};
      diff_out       = eg - el;
   end
endmodule

// ===== rtl/fpadd_addnorm.sv =====
// Stages 2 and 3 logic: alignment shift, add/subtract and normalisation
module fpadd_addnorm (
   input  fpadd_pkg::align_type align_in,
   input  logic [6:0]           diff_in,
   output fpadd_pkg::norm_type  norm_out,
   input  fpadd_pkg::norm_type  norm_in,
   output fpadd_pkg::round_type round_out
);
   logic [11:0] mb_sh, lost;
   logic [11:0] s;
   logic [7:0]  e;
   logic [3:0]  lz, sh;

   always_comb begin
      // alignment with sticky
      lost  = 12'd0;
      mb_sh = 12'd0;
      if (diff_in > 7'd13) begin
         mb_sh = {11'd0, align_in.mb != 12'd0};
      end else begin
         mb_sh = align_in.mb >> diff_in[3:0];
         lost  = align_in.mb & ((12'd1 << diff_in[3:0]) - 12'd1);
         mb_sh[0] = mb_sh[0] | (lost != 12'd0);
      end
      norm_out.special     = align_in.special;
      norm_out.special_val = align_in.special_val;
      norm_out.sign        = align_in.sign;
      norm_out.exp         = {1'b0, align_in.exp};
      norm_out.sum = align_in.sub ? ({1'b0, align_in.ma} - {1'b0, mb_sh})
                                  : ({1'b0, align_in.ma} + {1'b0, mb_sh});

      // normalisation
      e = norm_in.exp;
      if (norm_in.sum[12]) begin
         s = norm_in.sum[12:1] | {11'd0, norm_in.sum[0]};
         e = e + 8'd1;
      end else begin
         s = norm_in.sum[11:0];
      end
      lz = fpadd_pkg::lzc12(s);
      // shift until bit 11 set or exponent reaches one
      if ({4'd0, lz} < e - 8'd1)
         sh = lz;
      else
         sh = 4'(e - 8'd1);
      round_out.special     = norm_in.special;
      round_out.special_val = norm_in.special_val;
      round_out.sign        = norm_in.sign;
      round_out.exp         = e - {4'd0, sh};
      round_out.sum         = s << sh;
   end
endmodule

// ===== rtl/fpadd_round.sv =====
// Stage 4 logic: round to nearest even and pack the result
module fpadd_round (
   input  fpadd_pkg::round_type round_in,
   output logic [15:0]          result_out
);
   logic [2:0] grs;
   logic [9:0] m;
   logic [7:0] e;

   always_comb begin
      grs = round_in.sum[2:0];
      m   = {1'b0, round_in.sum[11:3]};
      e   = round_in.exp;
      if (grs > 3'd4 || (grs == 3'd4 && m[0]))
         m = m + 10'd1;
      if (m[9]) begin
         m = m >> 1;
         e = e + 8'd1;
      end
      if (round_in.special)
         result_out = round_in.special_val;
      else if (e >= {1'b0, fpadd_pkg::EXP_MAX})
         result_out = fpadd_pkg::INF_POS | {round_in.sign, 15'd0};
      else if (!m[8])
         result_out = {round_in.sign, 7'd0, m[7:0]};
      else
         result_out = {round_in.sign, e[6:0], m[7:0]};
   end
endmodule

// ===== sim/fp16_e7m8_adder_tb.sv =====
// Testbench for the e7m8 floating-point adder: directed and random sums checked against a predictor
module fp16_e7m8_adder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [6:0]  EXP_ALL  = 7'h7F;
   localparam logic [15:0] QNAN     = 16'hFF01;
   localparam logic [15:0] POS_INF  = 16'h7F00;
   localparam logic [15:0] NEG_INF  = 16'hFF00;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_operand_a = '0;
   logic [15:0] req_operand_b = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_sum;

   logic [15:0] sum_queue[$];
   int          n_errors = 0;
   bit          sink_busy_ok = 1'b1;
   int          sink_wait = 0;

   fp16_e7m8_adder i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_sum(rsp_sum)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // expected rounded sum of two e7m8 values
   function automatic logic [15:0] e7m8_sum(input logic [15:0] a_in, input logic [15:0] b_in);
      logic [15:0] a, b, t;
      logic [6:0]  ea, eb;
      logic [7:0]  fa, fb;
      logic        sa, sb, st;
      int unsigned ma, mb, d, e, s, m, grs;
      a = a_in; b = b_in;
      ea = a[14:8]; eb = b[14:8]; fa = a[7:0]; fb = b[7:0];
      sa = a[15]; sb = b[15];
      if ((ea == EXP_ALL && fa != 0) || (eb == EXP_ALL && fb != 0)) return QNAN;
      if (ea == EXP_ALL && eb == EXP_ALL && sa != sb) return QNAN;
      if (ea == EXP_ALL) return a;
      if (eb == EXP_ALL) return b;
      if (b[14:0] > a[14:0]) begin
         t = a; a = b; b = t;
         ea = a[14:8]; eb = b[14:8]; fa = a[7:0]; fb = b[7:0];
         sa = a[15]; sb = b[15];
      end
      if (a[14:0] == b[14:0] && sa != sb) return 16'h0000;
      if (a[14:0] == 0) return {sa & sb, 15'h0};
      ma = {24'd0, fa} | ((ea != 0) ? 32'h100 : 32'h0);
      mb = {24'd0, fb} | ((eb != 0) ? 32'h100 : 32'h0);
      if (ea == 0) ea = 7'd1;
      if (eb == 0) eb = 7'd1;
      d = 32'(ea) - 32'(eb);
      ma = ma << 3;
      mb = mb << 3;
      if (d > 13) mb = (mb != 0) ? 32'd1 : 32'd0;
      else if (d > 0) begin
         st = (mb & ((32'd1 << d) - 32'd1)) != 0;
         mb = (mb >> d) | {31'd0, st};
      end
      s = (sa == sb) ? ma + mb : ma - mb;
      e = 32'(ea);
      if (s >= 32'h1000) begin
         s = (s >> 1) | (s & 1);
         e++;
      end
      while (s < 32'h800 && e > 1) begin
         s = s << 1;
         e--;
      end
      grs = s & 7;
      m = s >> 3;
      if (grs > 4 || (grs == 4 && m[0])) m++;
      if (m >= 32'h200) begin
         m = m >> 1;
         e++;
      end
      if (e >= EXP_ALL) return {sa, POS_INF[14:0]};
      if (m < 32'h100) e = 0;
      return {sa, e[6:0], m[7:0]};
   endfunction

   // result side: may stall after each beat and checks each beat against the oldest expectation
   always @(posedge clock) begin
      logic [15:0] want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (sum_queue.size() == 0) begin
               $display("%0t: unexpected sum beat, expected none, actual %h", $time, rsp_sum);
               n_errors++;
            end else begin
               want = sum_queue.pop_front();
               if (rsp_sum !== want) begin
                  $display("%0t: sum mismatch, expected %h, actual %h", $time, want, rsp_sum);
                  n_errors++;
               end
            end
            sink_wait = sink_busy_ok ? int'($urandom_range(0, 3)) : 0;
         end else if (sink_wait > 0) begin
            sink_wait--;
         end
         rsp_stall <= (sink_wait != 0);
      end
   end

   // valid stays high between back-to-back beats; it drops only for a gap
   task automatic send_sum(input logic [15:0] a, input logic [15:0] b);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operand_a <= a;
      req_operand_b <= b;
      sum_queue.push_back(e7m8_sum(a, b));
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      do @(posedge clock); while (sum_queue.size() != 0);
   endtask

   task automatic test_directed;
      logic [15:0] v[$];
      v = '{16'h0000, 16'h8000, 16'h0001, 16'h80FF, 16'h00FF, 16'h0100, 16'h3F00,
            16'hBF00, 16'h7EFF, 16'hFEFF, POS_INF, NEG_INF, 16'h7F80, 16'hFFFF};
      send_sum(16'h0000, 16'h8000);
      send_sum(16'h8000, 16'h8000);
      send_sum(POS_INF, NEG_INF);
      send_sum(POS_INF, 16'h3F00);
      send_sum(16'h3C00, NEG_INF);
      send_sum(16'h7F01, 16'h0000);
      send_sum(16'h0000, 16'hFF80);
      send_sum(16'h3F55, 16'hBF55);
      send_sum(16'h7EFF, 16'h7EFF);
      send_sum(16'h7EFF, 16'h7880);
      send_sum(16'h00FF, 16'h0001);
      send_sum(16'h0100, 16'h80FF);
      send_sum(16'h7E00, 16'h0001);
      send_sum(16'h3F01, 16'h3481);
      send_sum(16'h3F03, 16'h3780);
      send_sum(16'h3F00, 16'hB601);
      foreach (v[i]) send_sum(v[i], v[(i + 5) % v.size()]);
   endtask

   task automatic test_pause_until_idle;
      send_sum(16'h4123, 16'hC456);
      drain();
      send_sum(16'h0080, 16'h0080);
   endtask

   // mostly finite values with near exponents; the rest fully random
   task automatic test_random;
      logic [15:0] a, b;
      for (int i = 0; i < 680; i++) begin
         a = 16'($urandom);
         b = 16'($urandom);
         case ($urandom_range(0, 5))
            0: ;
            1: b[14:8] = a[14:8] + 7'($urandom_range(0, 2));
            2: b = {~a[15], a[14:8], a[7:0] ^ 8'($urandom_range(0, 3))};
            3: begin
               a[14:8] = 7'($urandom_range(0, 2));
               b[14:8] = 7'($urandom_range(0, 2));
            end
            4: begin
               a[14:8] = 7'($urandom_range(120, 126));
               b[14:8] = a[14:8];
            end
            default: b[14:8] = a[14:8] - 7'($urandom_range(0, 16));
         endcase
         if (i % 100 < 10) sink_busy_ok = 1'b0;
         else sink_busy_ok = 1'b1;
         send_sum(a, b);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_pause_until_idle();
      test_random();
      drain();
      repeat (10) @(posedge clock);
      if (n_errors == 0) $display("PASS fp16_e7m8_adder");
      else $display("FAIL fp16_e7m8_adder");
      $finish;
   end

   initial begin
      #200us;
      $display("FAIL fp16_e7m8_adder");
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/fpadd_pkg.sv
rtl/fpadd_unpack.sv
rtl/fpadd_addnorm.sv
rtl/fpadd_round.sv
rtl/fp16_e7m8_adder.sv
sim/fp16_e7m8_adder_tb.sv
